// ===== rtl/core/bth_pkg.sv =====
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types and constants for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int HEAP_BYTES  = 4096;
  localparam int START_BYTES = 1024;
  localparam int GROW_BYTES  = 1024;
  localparam int AW          = $clog2(HEAP_BYTES);
  localparam int ACT_W       = AW + 1;
  localparam int OFF_W       = 34;
  localparam int TAG_OVERHEAD = 9;
  localparam int DATA_SKIP    = 5;
  localparam int TRAILER_LEN  = 4;
  localparam int START_EFF   = (START_BYTES <= HEAP_BYTES) ? START_BYTES : HEAP_BYTES;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [11:0] request_size;
    logic [11:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [11:0] data_offset;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLR, S_INIT, S_IDLE, S_LD_ISSUE, S_LD_WAIT, S_ST,
    S_SB_HDR, S_SB_FLAG, S_SB_TRL,
    S_A_WALK, S_A_FLAG, S_A_CHK, S_A_SPLIT2, S_G_LAST, S_G_FLAG,
    S_F_SIZE, S_F_NFLAG, S_F_NSIZE, S_F_LEFT, S_F_PS, S_F_PFLAG, S_F_WRITE,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/boundary_tag_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_unit
// First-fit boundary-tag allocator over a byte-wide heap memory.
// ----------------------------------------------------------------------------
// One item at a time. The heap lives in a byte RAM with one read port and one
// write port and a registered read; every 32-bit tag costs four byte reads or
// four byte writes. An allocate walks the block chain from offset zero and
// repeats the walk after each heap growth step. After reset a clearing pass
// over all HEAP_BYTES bytes plus the initial block write runs with in_stall
// high. A finished result waits in an output register.
module boundary_tag_heap_allocator_unit import bth_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [7:0] mem [HEAP_BYTES];
  logic [7:0] rd_q_r;
  logic       rd_oob_r;

  state_t state_r, state_nxt, ret_r, ret_nxt, sb_ret_r, sb_ret_nxt;
  logic [OFF_W-1:0] ld_addr_r, ld_addr_nxt, st_addr_r, st_addr_nxt;
  logic [1:0]       ld_cnt_r, ld_cnt_nxt, st_cnt_r, st_cnt_nxt;
  logic             ld_len4_r, ld_len4_nxt, st_len4_r, st_len4_nxt;
  logic [31:0]      ld_val_r, ld_val_nxt, st_val_r, st_val_nxt;
  logic [OFF_W-1:0] off_r, off_nxt, hdr_r, hdr_nxt, fsize_r, fsize_nxt;
  logic [31:0]      sz_r, sz_nxt;
  logic [11:0]      want_r, want_nxt;
  logic [ACT_W-1:0] active_r, active_nxt;
  logic [OFF_W-1:0] sb_hdr_r, sb_hdr_nxt;
  logic [31:0]      sb_size_r, sb_size_nxt;
  logic             sb_flag_r, sb_flag_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  out_item_t        res_r, res_nxt, out_r, out_nxt;
  logic             ov_r, ov_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;
  logic [OFF_W-1:0] rd_a, wr_a, act_w, want_w, sz_w;
  logic             rd_oob;
  logic [7:0]       rd_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r   <= mem[mem_raddr];
    rd_oob_r <= rd_oob;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      ret_r    <= S_IDLE;
      sb_ret_r <= S_IDLE;
      clr_r    <= '0;
      active_r <= ACT_W'(START_EFF);
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      sb_ret_r <= sb_ret_nxt;
      clr_r    <= clr_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_addr_r <= ld_addr_nxt;
    ld_cnt_r  <= ld_cnt_nxt;
    ld_len4_r <= ld_len4_nxt;
    ld_val_r  <= ld_val_nxt;
    st_addr_r <= st_addr_nxt;
    st_cnt_r  <= st_cnt_nxt;
    st_len4_r <= st_len4_nxt;
    st_val_r  <= st_val_nxt;
    off_r     <= off_nxt;
    hdr_r     <= hdr_nxt;
    fsize_r   <= fsize_nxt;
    sz_r      <= sz_nxt;
    want_r    <= want_nxt;
    sb_hdr_r  <= sb_hdr_nxt;
    sb_size_r <= sb_size_nxt;
    sb_flag_r <= sb_flag_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign act_w   = OFF_W'(active_r);
  assign want_w  = OFF_W'(want_r);
  assign sz_w    = OFF_W'(sz_r);
  assign rd_a    = ld_addr_r + OFF_W'(ld_cnt_r);
  assign wr_a    = st_addr_r + OFF_W'(st_cnt_r);
  assign rd_oob  = rd_a[OFF_W-1:AW] != '0;
  assign rd_byte = rd_oob_r ? 8'd0 : rd_q_r;
  assign mem_raddr = rd_a[AW-1:0];

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = ov_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    sb_ret_nxt  = sb_ret_r;
    ld_addr_nxt = ld_addr_r;
    ld_cnt_nxt  = ld_cnt_r;
    ld_len4_nxt = ld_len4_r;
    ld_val_nxt  = ld_val_r;
    st_addr_nxt = st_addr_r;
    st_cnt_nxt  = st_cnt_r;
    st_len4_nxt = st_len4_r;
    st_val_nxt  = st_val_r;
    off_nxt     = off_r;
    hdr_nxt     = hdr_r;
    fsize_nxt   = fsize_r;
    sz_nxt      = sz_r;
    want_nxt    = want_r;
    sb_hdr_nxt  = sb_hdr_r;
    sb_size_nxt = sb_size_r;
    sb_flag_nxt = sb_flag_r;
    clr_nxt     = clr_r;
    active_nxt  = active_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    ov_nxt      = ov_r && out_stall;
    mem_we      = 1'b0;
    mem_waddr   = wr_a[AW-1:0];
    mem_wdata   = st_val_r[{st_cnt_r, 3'b000} +: 8];

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 8'd0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(HEAP_BYTES - 1)) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        sb_hdr_nxt  = '0;
        sb_size_nxt = 32'(START_EFF - TAG_OVERHEAD);
        sb_flag_nxt = 1'b0;
        sb_ret_nxt  = S_IDLE;
        state_nxt   = S_SB_HDR;
      end
      S_IDLE: begin
        if (in_valid) begin
          want_nxt = in_item.request_size;
          res_nxt  = '{data_offset: 12'd0, status: ST_OK};
          if (in_item.operation == OP_ALLOC) begin
            off_nxt   = '0;
            state_nxt = S_A_WALK;
          end else if (in_item.block_offset < 12'(DATA_SKIP)) begin
            res_nxt.status = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            hdr_nxt     = OFF_W'(in_item.block_offset) - OFF_W'(DATA_SKIP);
            ld_addr_nxt = OFF_W'(in_item.block_offset) - OFF_W'(DATA_SKIP);
            ld_len4_nxt = 1'b1;
            ld_cnt_nxt  = '0;
            ld_val_nxt  = '0;
            ret_nxt     = S_F_SIZE;
            state_nxt   = S_LD_ISSUE;
          end
        end
      end
      S_LD_ISSUE: begin
        state_nxt = S_LD_WAIT;
      end
      S_LD_WAIT: begin
        ld_val_nxt[{ld_cnt_r, 3'b000} +: 8] = rd_byte;
        if (!ld_len4_r || ld_cnt_r == 2'd3) begin
          state_nxt = ret_r;
        end else begin
          ld_cnt_nxt = ld_cnt_r + 2'd1;
          state_nxt  = S_LD_ISSUE;
        end
      end
      S_ST: begin
        mem_we = wr_a[OFF_W-1:AW] == '0;
        if (!st_len4_r || st_cnt_r == 2'd3) begin
          state_nxt = ret_r;
        end else begin
          st_cnt_nxt = st_cnt_r + 2'd1;
        end
      end
      S_SB_HDR: begin
        st_addr_nxt = sb_hdr_r;
        st_val_nxt  = sb_size_r;
        st_len4_nxt = 1'b1;
        st_cnt_nxt  = '0;
        ret_nxt     = S_SB_FLAG;
        state_nxt   = S_ST;
      end
      S_SB_FLAG: begin
        st_addr_nxt = sb_hdr_r + OFF_W'(4);
        st_val_nxt  = {31'd0, sb_flag_r};
        st_len4_nxt = 1'b0;
        st_cnt_nxt  = '0;
        ret_nxt     = S_SB_TRL;
        state_nxt   = S_ST;
      end
      S_SB_TRL: begin
        st_addr_nxt = sb_hdr_r + OFF_W'(DATA_SKIP) + OFF_W'(sb_size_r);
        st_val_nxt  = sb_size_r;
        st_len4_nxt = 1'b1;
        st_cnt_nxt  = '0;
        ret_nxt     = sb_ret_r;
        state_nxt   = S_ST;
      end
      S_A_WALK: begin
        ld_cnt_nxt  = '0;
        ld_val_nxt  = '0;
        ld_len4_nxt = 1'b1;
        if (off_r < act_w) begin
          ld_addr_nxt = off_r;
          ret_nxt     = S_A_FLAG;
          state_nxt   = S_LD_ISSUE;
        end else if (act_w + OFF_W'(GROW_BYTES) > OFF_W'(HEAP_BYTES)) begin
          res_nxt.status = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          ld_addr_nxt = act_w - OFF_W'(TRAILER_LEN);
          ret_nxt     = S_G_LAST;
          state_nxt   = S_LD_ISSUE;
        end
      end
      S_A_FLAG: begin
        sz_nxt      = ld_val_r;
        ld_addr_nxt = off_r + OFF_W'(4);
        ld_len4_nxt = 1'b0;
        ld_cnt_nxt  = '0;
        ld_val_nxt  = '0;
        ret_nxt     = S_A_CHK;
        state_nxt   = S_LD_ISSUE;
      end
      S_A_CHK: begin
        if (!ld_val_r[0] && sz_w >= want_w) begin
          res_nxt.data_offset = 12'(off_r + OFF_W'(DATA_SKIP));
          if (sz_r - 32'(want_r) > 32'(TAG_OVERHEAD)) begin
            sb_hdr_nxt  = off_r;
            sb_size_nxt = 32'(want_r);
            sb_flag_nxt = 1'b1;
            sb_ret_nxt  = S_A_SPLIT2;
            state_nxt   = S_SB_HDR;
          end else begin
            st_addr_nxt = off_r + OFF_W'(4);
            st_val_nxt  = 32'd1;
            st_len4_nxt = 1'b0;
            st_cnt_nxt  = '0;
            ret_nxt     = S_DONE;
            state_nxt   = S_ST;
          end
        end else begin
          off_nxt   = off_r + sz_w + OFF_W'(TAG_OVERHEAD);
          state_nxt = S_A_WALK;
        end
      end
      S_A_SPLIT2: begin
        sb_hdr_nxt  = off_r + want_w + OFF_W'(TAG_OVERHEAD);
        sb_size_nxt = sz_r - 32'(want_r) - 32'(TAG_OVERHEAD);
        sb_flag_nxt = 1'b0;
        sb_ret_nxt  = S_DONE;
        state_nxt   = S_SB_HDR;
      end
      S_G_LAST: begin
        sz_nxt     = ld_val_r;
        hdr_nxt    = act_w;
        active_nxt = active_r + ACT_W'(GROW_BYTES);
        off_nxt    = '0;
        sb_flag_nxt = 1'b0;
        sb_ret_nxt  = S_A_WALK;
        if (OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD) <= act_w) begin
          hdr_nxt     = act_w - OFF_W'(TAG_OVERHEAD) - OFF_W'(ld_val_r);
          ld_addr_nxt = act_w - OFF_W'(TAG_OVERHEAD) - OFF_W'(ld_val_r) + OFF_W'(4);
          ld_len4_nxt = 1'b0;
          ld_cnt_nxt  = '0;
          ld_val_nxt  = '0;
          ret_nxt     = S_G_FLAG;
          state_nxt   = S_LD_ISSUE;
        end else begin
          sb_hdr_nxt  = act_w;
          sb_size_nxt = 32'(GROW_BYTES - TAG_OVERHEAD);
          state_nxt   = S_SB_HDR;
        end
      end
      S_G_FLAG: begin
        if (!ld_val_r[0]) begin
          sb_hdr_nxt  = hdr_r;
          sb_size_nxt = sz_r + 32'(GROW_BYTES);
        end else begin
          sb_hdr_nxt  = act_w - OFF_W'(GROW_BYTES);
          sb_size_nxt = 32'(GROW_BYTES - TAG_OVERHEAD);
        end
        state_nxt = S_SB_HDR;
      end
      S_F_SIZE: begin
        fsize_nxt = OFF_W'(ld_val_r);
        off_nxt   = hdr_r + OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD);
        if (hdr_r + OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD) > act_w) begin
          res_nxt.status = ST_RANGE;
          state_nxt      = S_DONE;
        end else if (hdr_r + OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD) < act_w) begin
          ld_addr_nxt = hdr_r + OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD) + OFF_W'(4);
          ld_len4_nxt = 1'b0;
          ld_cnt_nxt  = '0;
          ld_val_nxt  = '0;
          ret_nxt     = S_F_NFLAG;
          state_nxt   = S_LD_ISSUE;
        end else begin
          state_nxt = S_F_LEFT;
        end
      end
      S_F_NFLAG: begin
        if (!ld_val_r[0]) begin
          ld_addr_nxt = off_r;
          ld_len4_nxt = 1'b1;
          ld_cnt_nxt  = '0;
          ld_val_nxt  = '0;
          ret_nxt     = S_F_NSIZE;
          state_nxt   = S_LD_ISSUE;
        end else begin
          state_nxt = S_F_LEFT;
        end
      end
      S_F_NSIZE: begin
        if (off_r + OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD) <= act_w) begin
          fsize_nxt = fsize_r + OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD);
        end
        state_nxt = S_F_LEFT;
      end
      S_F_LEFT: begin
        if (hdr_r >= OFF_W'(TAG_OVERHEAD)) begin
          ld_addr_nxt = hdr_r - OFF_W'(TRAILER_LEN);
          ld_len4_nxt = 1'b1;
          ld_cnt_nxt  = '0;
          ld_val_nxt  = '0;
          ret_nxt     = S_F_PS;
          state_nxt   = S_LD_ISSUE;
        end else begin
          state_nxt = S_F_WRITE;
        end
      end
      S_F_PS: begin
        sz_nxt = ld_val_r;
        if (OFF_W'(ld_val_r) + OFF_W'(TAG_OVERHEAD) <= hdr_r) begin
          ld_addr_nxt = hdr_r - OFF_W'(TAG_OVERHEAD) - OFF_W'(ld_val_r) + OFF_W'(4);
          ld_len4_nxt = 1'b0;
          ld_cnt_nxt  = '0;
          ld_val_nxt  = '0;
          ret_nxt     = S_F_PFLAG;
          state_nxt   = S_LD_ISSUE;
        end else begin
          state_nxt = S_F_WRITE;
        end
      end
      S_F_PFLAG: begin
        if (!ld_val_r[0]) begin
          hdr_nxt   = hdr_r - OFF_W'(TAG_OVERHEAD) - sz_w;
          fsize_nxt = fsize_r + sz_w + OFF_W'(TAG_OVERHEAD);
        end
        state_nxt = S_F_WRITE;
      end
      S_F_WRITE: begin
        sb_hdr_nxt  = hdr_r;
        sb_size_nxt = fsize_r[31:0];
        sb_flag_nxt = 1'b0;
        sb_ret_nxt  = S_DONE;
        state_nxt   = S_SB_HDR;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bth_checker.sv =====
// ----------------------------------------------------------------------------
// bth_checker
// Port-level checks for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
module bth_checker import bth_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_clear_busy: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_NO_SPACE ||
                   out_item.status == ST_RANGE))
    else $error("undefined status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.data_offset == 12'd0)
    else $error("offset on failed item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind boundary_tag_heap_allocator_unit bth_checker u_bth_checker (.*);

// ===== test/tb_boundary_tag_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator_unit
// Self-checking bench for the first-fit boundary-tag heap allocator.
// ----------------------------------------------------------------------------
// A directed table of allocate and free items runs first, then random
// allocate/free traffic that mostly frees live blocks. A shadow heap predicts
// every result; results are compared field by field in arrival order, with
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_boundary_tag_heap_allocator_unit;
  import bth_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  boundary_tag_heap_allocator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } row_t;

  logic [7:0]  shadow_heap [HEAP_BYTES];
  int unsigned shadow_active;
  out_item_t   pending_results [$];
  int unsigned live_blocks [$];
  int          error_count;
  int          result_count;
  int          alloc_count;
  int          free_count;
  int          no_space_count;
  int          range_count;
  bit          hold_off_req;
  row_t        rows [$];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #300ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned rd8(longint unsigned a);
    return (a < HEAP_BYTES) ? shadow_heap[a] : 0;
  endfunction

  function automatic void wr8(longint unsigned a, int unsigned v);
    if (a < HEAP_BYTES) shadow_heap[a] = v[7:0];
  endfunction

  function automatic longint unsigned rd32(longint unsigned a);
    return rd8(a) | (rd8(a + 1) << 8) | (rd8(a + 2) << 16) | (longint'(rd8(a + 3)) << 24);
  endfunction

  function automatic void wr32(longint unsigned a, longint unsigned v);
    for (int k = 0; k < 4; k++) wr8(a + k, 32'((v >> (8 * k)) & 64'hff));
  endfunction

  function automatic void write_tags(longint unsigned hdr, longint unsigned sz,
                                     int unsigned flag);
    wr32(hdr, sz);
    wr8(hdr + 4, flag);
    wr32(hdr + DATA_SKIP + sz, sz);
  endfunction

  function automatic void heap_reset();
    for (int k = 0; k < HEAP_BYTES; k++) shadow_heap[k] = 8'h00;
    shadow_active = START_EFF;
    write_tags(0, START_EFF - TAG_OVERHEAD, 0);
  endfunction

  function automatic longint unsigned find_first_fit(longint unsigned want);
    longint unsigned off;
    longint unsigned sz;
    off = 0;
    while (off < shadow_active) begin
      sz = rd32(off);
      if ((rd8(off + 4) & 1) == 0 && sz >= want) return off;
      off += sz + TAG_OVERHEAD;
    end
    return off;
  endfunction

  function automatic void grow_shadow();
    longint unsigned old;
    longint unsigned last;
    old = shadow_active;
    last = rd32(old - TRAILER_LEN);
    shadow_active = old + GROW_BYTES;
    if (last + TAG_OVERHEAD <= old && (rd8(old - TAG_OVERHEAD - last + 4) & 1) == 0)
      write_tags(old - TAG_OVERHEAD - last, (last + GROW_BYTES) & 32'hffffffff, 0);
    else
      write_tags(old, GROW_BYTES - TAG_OVERHEAD, 0);
  endfunction

  function automatic out_item_t predict_heap_op(in_item_t it);
    out_item_t r;
    longint unsigned off, have, want, p, hdr, nxt, sz, ns, ps, ph;
    r = '0;
    want = it.request_size;
    p = it.block_offset;
    if (it.operation == OP_ALLOC) begin
      forever begin
        off = find_first_fit(want);
        if (off < shadow_active) break;
        if (shadow_active + GROW_BYTES > HEAP_BYTES) begin
          r.status = ST_NO_SPACE;
          return r;
        end
        grow_shadow();
      end
      have = rd32(off);
      if (((have - want) & 32'hffffffff) > TAG_OVERHEAD) begin
        write_tags(off, want, 1);
        write_tags(off + want + TAG_OVERHEAD, have - want - TAG_OVERHEAD, 0);
      end else begin
        wr8(off + 4, 1);
      end
      r.data_offset = 12'(off + DATA_SKIP);
      return r;
    end
    if (p < DATA_SKIP) begin
      r.status = ST_RANGE;
      return r;
    end
    hdr = p - DATA_SKIP;
    sz = rd32(hdr);
    if (hdr + sz + TAG_OVERHEAD > shadow_active) begin
      r.status = ST_RANGE;
      return r;
    end
    nxt = hdr + sz + TAG_OVERHEAD;
    if (nxt < shadow_active && (rd8(nxt + 4) & 1) == 0) begin
      ns = rd32(nxt);
      if (nxt + ns + TAG_OVERHEAD <= shadow_active) sz += ns + TAG_OVERHEAD;
    end
    if (hdr >= TAG_OVERHEAD) begin
      ps = rd32(hdr - TRAILER_LEN);
      if (ps + TAG_OVERHEAD <= hdr) begin
        ph = hdr - TAG_OVERHEAD - ps;
        if ((rd8(ph + 4) & 1) == 0) begin
          hdr = ph;
          sz += ps + TAG_OVERHEAD;
        end
      end
    end
    write_tags(hdr, sz & 32'hffffffff, 0);
    return r;
  endfunction

  function automatic int unsigned short_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
  endfunction

  task automatic send_item(in_item_t it, logic known, out_item_t want_res);
    out_item_t r;
    r = predict_heap_op(it);
    if (known && r !== want_res) begin
      $error("table row: data_offset expected %0d got %0d, status expected %0d got %0d",
             want_res.data_offset, r.data_offset, want_res.status, r.status);
      error_count++;
    end
    pending_results.push_back(r);
    if (it.operation == OP_ALLOC) begin
      alloc_count++;
      if (r.status == ST_OK) live_blocks.push_back(r.data_offset);
      else no_space_count++;
    end else begin
      free_count++;
      if (r.status == ST_RANGE) range_count++;
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input(int unsigned n);
    if (n == 0) return;
    in_valid <= 1'b0;
    in_item  <= in_item_t'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic op, int unsigned sz, int unsigned off);
    in_item_t it;
    it.operation    = op;
    it.request_size = sz[11:0];
    it.block_offset = off[11:0];
    return it;
  endfunction

  function automatic void add_row(in_item_t it, logic known, int unsigned doff,
                                  logic [1:0] st);
    row_t rw;
    rw.item = it;
    rw.known = known;
    rw.result.data_offset = doff[11:0];
    rw.result.status = st;
    rows.push_back(rw);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: data_offset %0d status %0d",
               out_item.data_offset, out_item.status);
        error_count++;
      end else begin
        automatic out_item_t w = pending_results.pop_front();
        if (out_item.data_offset !== w.data_offset) begin
          $error("data_offset expected %0d actual %0d", w.data_offset, out_item.data_offset);
          error_count++;
        end
        if (out_item.status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, out_item.status);
          error_count++;
        end
        result_count++;
      end
    end
  end

  initial begin
    int unsigned n;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off_req = 1'b0;
      end
      n = short_gap();
      if (($urandom_range(0, 7) == 0) || n == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 1) == 1);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned idx, sz, op_pick;
    in_item_t it;
    error_count = 0;
    result_count = 0;
    alloc_count = 0;
    free_count = 0;
    no_space_count = 0;
    range_count = 0;
    hold_off_req = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    heap_reset();

    add_row(mk(OP_ALLOC, 0, 0), 1'b1, 5, ST_OK);
    add_row(mk(OP_FREE, 0, 0), 1'b1, 0, ST_RANGE);
    add_row(mk(OP_FREE, 0, 4), 1'b1, 0, ST_RANGE);
    add_row(mk(OP_FREE, 0, 4095), 1'b0, 0, ST_OK);
    add_row(mk(OP_ALLOC, 100, 0), 1'b1, 14, ST_OK);
    add_row(mk(OP_ALLOC, 10, 0), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 14), 1'b1, 0, ST_OK);
    add_row(mk(OP_ALLOC, 95, 0), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 14), 1'b1, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 14), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 5), 1'b0, 0, ST_OK);
    add_row(mk(OP_ALLOC, 2000, 0), 1'b0, 0, ST_OK);
    add_row(mk(OP_ALLOC, 4087, 0), 1'b1, 0, ST_NO_SPACE);
    add_row(mk(OP_ALLOC, 3000, 0), 1'b0, 0, ST_OK);
    add_row(mk(OP_ALLOC, 1500, 0), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 2000), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 2730), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 4095, 1365), 1'b0, 0, ST_OK);
    add_row(mk(OP_ALLOC, 1, 4095), 1'b0, 0, ST_OK);
    add_row(mk(OP_FREE, 0, 3000), 1'b0, 0, ST_OK);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      send_item(rows[r].item, rows[r].known, rows[r].result);
      idle_input(short_gap());
    end
    drain_results();
    live_blocks.delete();

    hold_off_req = 1'b1;
    for (int k = 0; k < 1380; k++) begin
      op_pick = $urandom_range(0, 99);
      if (op_pick < 45 || (live_blocks.size() == 0 && op_pick < 80)) begin
        case ($urandom_range(0, 9))
          0: sz = $urandom_range(0, 4087);
          1: sz = $urandom_range(0, 12);
          2: sz = $urandom_range(500, 1500);
          default: sz = $urandom_range(0, 200);
        endcase
        it = mk(OP_ALLOC, sz, $urandom);
      end else if (op_pick < 88 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        it = mk(OP_FREE, $urandom, live_blocks[idx]);
        live_blocks.delete(idx);
      end else begin
        it = mk(OP_FREE, $urandom, $urandom);
        live_blocks.delete();
      end
      send_item(it, 1'b0, '0);
      if (k == 700) drain_results();
      else idle_input(short_gap());
    end
    drain_results();
    repeat (200) @(posedge clk);

    $display("Covered %0d allocates (%0d no space) and %0d frees (%0d out of range).",
             alloc_count, no_space_count, free_count, range_count);
    $display("Checked %0d results with random gaps and output stalls.", result_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
